// File: src/cvoc_pkg.sv
// Shared types, constants and elaboration-time coefficient helpers for the channel vocoder.
`default_nettype none

package cvoc_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_BANDS_DEF   = 16;
    localparam int SAMPLE_RATE_DEF = 48000;

    // Configuration register indexes
    localparam logic [1:0] REG_BAND_COUNT  = 2'd0;
    localparam logic [1:0] REG_LEVELS_LOW  = 2'd1;
    localparam logic [1:0] REG_LEVELS_HIGH = 2'd2;
    localparam logic [1:0] REG_MAIN_VOLUME = 2'd3;

    // Fixed-point constants (Q32 and Q20)
    localparam logic [63:0] ONE_Q32    = 64'd1 << 32;
    localparam logic [63:0] LN_123_Q32 = 64'd889119087;
    localparam logic [63:0] TWO_PI_Q20 = 64'd6588397;
    localparam logic [22:0] COEF_MAX   = 23'h7FFFFF;

    // Per-band sequencer states, one-hot
    typedef enum logic [19:0] {
        ST_IDLE = 20'h00001,
        ST_RD   = 20'h00002,
        ST_LD   = 20'h00004,
        ST_M1   = 20'h00008,
        ST_H1   = 20'h00010,
        ST_M2   = 20'h00020,
        ST_U1   = 20'h00040,
        ST_M3   = 20'h00080,
        ST_H2   = 20'h00100,
        ST_M4   = 20'h00200,
        ST_U2   = 20'h00400,
        ST_M5   = 20'h00800,
        ST_Y    = 20'h01000,
        ST_E1   = 20'h02000,
        ST_E2   = 20'h04000,
        ST_C1   = 20'h08000,
        ST_C2   = 20'h10000,
        ST_AC   = 20'h20000,
        ST_V1   = 20'h40000,
        ST_OUT  = 20'h80000
    } cvoc_state_t;

    // Band coefficients, Q5.18 non-negative, and the envelope decay
    typedef struct packed {
        logic [22:0] c2;
        logic [22:0] f;
        logic [22:0] att;
        logic [11:0] decay;
    } cvoc_coef_t;

    // Four filter words of one band: mid1, low1, mid2, low2
    typedef logic [3:0][31:0] cvoc_row_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        begin
            if (v > 40'sd2147483647)
                r = 32'sh7FFFFFFF;
            else if (v < -40'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

    function automatic logic [22:0] clamp_coef(input logic [63:0] v);
        return (v > 64'(COEF_MAX)) ? COEF_MAX : v[22:0];
    endfunction

    // e^t in Q32, twelve series terms, t limited below 1.0
    function automatic logic [63:0] exp_q32(input logic [63:0] t_in);
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] sum;
        begin
            t    = (t_in >= ONE_Q32) ? ONE_Q32 - 64'd1 : t_in;
            term = ONE_Q32;
            sum  = ONE_Q32;
            term = ((term * t) >> 32) / 64'd1;  sum = sum + term;
            term = ((term * t) >> 32) / 64'd2;  sum = sum + term;
            term = ((term * t) >> 32) / 64'd3;  sum = sum + term;
            term = ((term * t) >> 32) / 64'd4;  sum = sum + term;
            term = ((term * t) >> 32) / 64'd5;  sum = sum + term;
            term = ((term * t) >> 32) / 64'd6;  sum = sum + term;
            term = ((term * t) >> 32) / 64'd7;  sum = sum + term;
            term = ((term * t) >> 32) / 64'd8;  sum = sum + term;
            term = ((term * t) >> 32) / 64'd9;  sum = sum + term;
            term = ((term * t) >> 32) / 64'd10; sum = sum + term;
            term = ((term * t) >> 32) / 64'd11; sum = sum + term;
            term = ((term * t) >> 32) / 64'd12; sum = sum + term;
            return sum;
        end
    endfunction

    // 1.23^k in Q32; k never exceeds eleven for a band in use
    function automatic logic [63:0] pow123(input logic [63:0] k);
        logic [63:0] p;
        begin
            p = ONE_Q32;
            for (int j = 0; j < 12; j++) begin
                if (64'(j) < k)
                    p = (p * 64'd123) / 64'd100;
            end
            return p;
        end
    endfunction

    function automatic logic [11:0] decay_lut(input logic [3:0] idx);
        logic [11:0] d;
        begin
            unique case (idx)
                4'd0, 4'd1, 4'd2, 4'd3:    d = 12'd2621;
                4'd4, 4'd5, 4'd6:          d = 12'd2097;
                4'd7, 4'd8, 4'd9:          d = 12'd1579;
                4'd10, 4'd11, 4'd12:       d = 12'd1311;
                default:                   d = 12'd1049;
            endcase
            return d;
        end
    endfunction

endpackage

`default_nettype wire

// File: src/cvoc_in_if.sv
// Input request channel: formant and carrier samples with end-of-block mark.
`default_nettype none

interface cvoc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] formant_sample;
    logic signed [15:0] carrier_sample;
    logic               end_of_block;

    modport source (output valid, formant_sample, carrier_sample, end_of_block, input ready);
    modport sink   (input valid, formant_sample, carrier_sample, end_of_block, output ready);
endinterface

`default_nettype wire

// File: src/cvoc_out_if.sv
// Output request channel: vocoded sample with echoed end-of-block mark.
`default_nettype none

interface cvoc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vocoded_sample;
    logic               end_of_block_out;

    modport source (output valid, vocoded_sample, end_of_block_out, input ready);
    modport sink   (input valid, vocoded_sample, end_of_block_out, output ready);
endinterface

`default_nettype wire

// File: src/cvoc_lane.sv
// One filter lane: two cascaded state-variable sections around a shared multiplier.
`default_nettype none

module cvoc_lane
    import cvoc_pkg::*;
(
    input  logic               clk,
    input  cvoc_state_t        state,
    input  cvoc_coef_t         coef,
    input  logic signed [16:0] x,
    input  cvoc_row_t          row_in,
    output cvoc_row_t          row_out,
    output logic signed [31:0] y
);

    logic signed [31:0] s0_reg, s1_reg, s2_reg, s3_reg;
    logic signed [31:0] s0_next, s1_next, s2_next, s3_next;
    logic signed [31:0] h_reg, h_next;
    logic signed [55:0] p_reg, p_next;
    logic signed [31:0] y_reg, y_next;

    logic signed [31:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [37:0] p_sh;

    assign p_sh = p_reg[55:18];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state)
            ST_M1:
            begin
                mul_a = s0_reg;
                mul_b = $signed({1'b0, coef.f});
            end
            ST_M2:
            begin
                mul_a = h_reg;
                mul_b = $signed({1'b0, coef.c2});
            end
            ST_M3:
            begin
                mul_a = s2_reg;
                mul_b = $signed({1'b0, coef.f});
            end
            ST_M4:
            begin
                mul_a = h_reg;
                mul_b = $signed({1'b0, coef.c2});
            end
            ST_M5:
            begin
                mul_a = h_reg;
                mul_b = $signed({1'b0, coef.att});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        p_next = mul_a * mul_b;
    end

    always_comb
    begin
        s0_next = s0_reg;
        s1_next = s1_reg;
        s2_next = s2_reg;
        s3_next = s3_reg;
        h_next  = h_reg;
        y_next  = y_reg;
        unique case (state)
            ST_LD:
            begin
                s0_next = $signed(row_in[0]);
                s1_next = $signed(row_in[1]);
                s2_next = $signed(row_in[2]);
                s3_next = $signed(row_in[3]);
            end
            ST_H1:
                h_next = sat32(40'(x) - 40'(p_sh) - 40'(s1_reg));
            ST_U1:
            begin
                s0_next = sat32(40'(s0_reg) + 40'(p_sh));
                s1_next = sat32(40'(s1_reg) + 40'(s0_next));
            end
            ST_H2:
                h_next = sat32(40'(s1_reg) - 40'(p_sh) - 40'(s3_reg));
            ST_U2:
            begin
                s2_next = sat32(40'(s2_reg) + 40'(p_sh));
                s3_next = sat32(40'(s3_reg) + 40'(s2_next));
            end
            ST_Y:
                y_next = sat32(40'(p_sh));
            default:
            begin
                h_next = h_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= s0_next;
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        s3_reg <= s3_next;
        h_reg  <= h_next;
        p_reg  <= p_next;
        y_reg  <= y_next;
    end

    assign row_out = {s3_reg, s2_reg, s1_reg, s0_reg};
    assign y       = y_reg;

endmodule

`default_nettype wire

// File: src/channel_vocoder.sv
// Channel vocoder top level: band sequencer, filter and envelope memories, output mix.
//
//  channel   | dir | payload                                          | handshake
//  ----------+-----+--------------------------------------------------+-------------
//  audio     | in  | formant_sample, carrier_sample (Q1.15), end_of_block | valid/ready
//  vocoded   | out | vocoded_sample (Q1.15, saturated), end_of_block_out  | valid/ready
//  cfg_*     | in  | cfg_index, cfg_data                              | cfg_write
//
// An item runs the band schedule once for each band in use, between the row read and
// the volume and output steps. The schedule has sixteen steps per band, since each lane
// has one multiplier that every filter step runs through in turn.
// Reset clears control state only; filter and envelope rows are masked by valid bits
// and read as zero until written, so no clearing pass is needed after reset.
// A new request is taken in idle even while the previous result waits on a stalled
// output; only the final load of the output register waits for it to drain.
`default_nettype none

module channel_vocoder
    import cvoc_pkg::*;
#(
    parameter int MAX_BAND_COUNT = MAX_BANDS_DEF,
    parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    cvoc_in_if.sink           audio,
    cvoc_out_if.source        vocoded,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [63:0]       cfg_data
);

    // Band index and band count widths
    localparam int BW    = (MAX_BAND_COUNT > 1) ? $clog2(MAX_BAND_COUNT) : 1;
    localparam int CW    = $clog2(MAX_BAND_COUNT + 1);
    // One band term is 43 bits; the sum grows by the band index width plus one bit
    localparam int ACC_W = 44 + BW;
    localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(16777216);
    localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_HI;

    // ------------------------------------------------------------------
    // Coefficient ROM, indexed by (band count - 1, band); built at elaboration
    // ------------------------------------------------------------------
    cvoc_coef_t coef_rom [MAX_BAND_COUNT][MAX_BAND_COUNT];

    for (genvar gn = 0; gn < MAX_BAND_COUNT; gn++)
    begin : g_cnt
        for (genvar gi = 0; gi < MAX_BAND_COUNT; gi++)
        begin : g_band
            localparam logic [63:0] N      = 64'(gn + 1);
            localparam logic [63:0] NUM    = 64'(16 * gi);
            // Lower bands sit on a linear frequency ramp from 150 Hz
            localparam logic [63:0] FQ_LIN = (64'd150 << 16) + ((64'd105 * NUM) << 16) / N;
            // Upper bands step geometrically by 1.23 from 600 Hz
            localparam logic [63:0] D      = (NUM >= 64'd4 * N) ? NUM - 64'd4 * N : 64'd0;
            localparam logic [63:0] K      = D / N;
            localparam logic [63:0] R      = D % N;
            localparam logic [63:0] E      = exp_q32((LN_123_Q32 * R) / N);
            localparam logic [63:0] M      = (pow123(K) >> 16) * (E >> 16);
            localparam logic [63:0] FQ_EXP = (64'd600 * M) >> 16;
            localparam logic [63:0] FQ     = (NUM < 64'd4 * N) ? FQ_LIN : FQ_EXP;
            localparam logic [63:0] C32_RAW =
                ((FQ * TWO_PI_Q20) / 64'(SAMPLE_RATE_HZ)) >> 4;
            localparam logic [63:0] C32    = (C32_RAW >= (64'd1 << 37)) ?
                                             (64'd1 << 37) - 64'd1 : C32_RAW;
            localparam logic [63:0] CS     = C32 >> 8;
            localparam logic [63:0] F_DIV  = (C32 == 64'd0) ? 64'd1 : C32;
            localparam logic [63:0] Y      = (FQ << 16) / 64'(SAMPLE_RATE_HZ);
            localparam logic [63:0] DEN    = 64'd6 * ONE_Q32 + 64'd10 * (exp_q32(Y) - ONE_Q32);
            localparam cvoc_coef_t COEF = '{
                c2:    clamp_coef((CS * CS) >> 30),
                f:     (C32 == 64'd0) ? COEF_MAX : clamp_coef(((64'd1 << 51) / 64'd5) / F_DIV),
                att:   clamp_coef((64'd1 << 50) / DEN),
                decay: decay_lut(4'((NUM / N) & 64'd15))
            };
            assign coef_rom[gn][gi] = COEF;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [4:0]  band_count_reg;
    logic [63:0] band_levels_low_reg;
    logic [63:0] band_levels_high_reg;
    logic [15:0] main_volume_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_count_reg       <= 5'd16;
            band_levels_low_reg  <= 64'h8080808080808080;
            band_levels_high_reg <= 64'h8080808080808080;
            main_volume_reg      <= 16'd256;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BAND_COUNT:  band_count_reg       <= cfg_data[4:0];
                REG_LEVELS_LOW:  band_levels_low_reg  <= cfg_data;
                REG_LEVELS_HIGH: band_levels_high_reg <= cfg_data;
                REG_MAIN_VOLUME: main_volume_reg      <= cfg_data[15:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    cvoc_state_t         state_reg, state_next;
    logic [BW-1:0]       band_reg, band_next;
    logic [CW-1:0]       active_reg, active_next;
    logic [MAX_BAND_COUNT-1:0] filt_valid_reg, filt_valid_next;
    logic [MAX_BAND_COUNT-1:0] env_valid_reg, env_valid_next;
    logic                out_valid_reg, out_valid_next;

    logic          in_acc;
    logic [CW-1:0] n_eff;
    logic          band_last;
    logic          out_load;
    logic          rd_en;
    logic [BW-1:0] rd_band;
    logic [BW-1:0] active_m1;

    assign in_acc    = audio.valid && audio.ready;
    // Zero, or more than the bank holds, selects the whole bank
    assign n_eff     = ({1'b0, band_count_reg} == 6'd0 ||
                        {1'b0, band_count_reg} > 6'(MAX_BAND_COUNT)) ?
                       CW'(MAX_BAND_COUNT) : CW'(band_count_reg);
    assign band_last = (CW'(band_reg) + CW'(1)) == active_reg;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || vocoded.ready);
    // The next band's row is fetched in the accumulate step of the current one
    assign rd_en     = (state_reg == ST_RD) || ((state_reg == ST_AC) && !band_last);
    assign rd_band   = (state_reg == ST_AC) ? band_reg + BW'(1) : band_reg;
    assign active_m1 = BW'(active_reg - CW'(1));

    always_comb
    begin
        state_next      = state_reg;
        band_next       = band_reg;
        active_next     = active_reg;
        filt_valid_next = filt_valid_reg;
        env_valid_next  = env_valid_reg;
        out_valid_next  = out_valid_reg;

        if (out_valid_reg && vocoded.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    band_next  = '0;
                    state_next = ST_RD;
                    // A new band count drops all filter history, envelopes stay
                    if (n_eff != active_reg)
                    begin
                        active_next     = n_eff;
                        filt_valid_next = '0;
                    end
                end
            end
            ST_RD: state_next = ST_LD;
            ST_LD: state_next = ST_M1;
            ST_M1: state_next = ST_H1;
            ST_H1: state_next = ST_M2;
            ST_M2: state_next = ST_U1;
            ST_U1: state_next = ST_M3;
            ST_M3: state_next = ST_H2;
            ST_H2: state_next = ST_M4;
            ST_M4: state_next = ST_U2;
            ST_U2: state_next = ST_M5;
            ST_M5:
            begin
                filt_valid_next[band_reg] = 1'b1;
                state_next = ST_Y;
            end
            ST_Y:  state_next = ST_E1;
            ST_E1: state_next = ST_E2;
            ST_E2:
            begin
                env_valid_next[band_reg] = 1'b1;
                state_next = ST_C1;
            end
            ST_C1: state_next = ST_C2;
            ST_C2: state_next = ST_AC;
            ST_AC:
            begin
                if (band_last)
                    state_next = ST_V1;
                else
                begin
                    band_next  = band_reg + BW'(1);
                    state_next = ST_LD;
                end
            end
            ST_V1: state_next = ST_OUT;
            ST_OUT:
            begin
                // Hold the finished sample until the output register frees up
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            band_reg       <= '0;
            active_reg     <= '0;
            filt_valid_reg <= '0;
            env_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            band_reg       <= band_next;
            active_reg     <= active_next;
            filt_valid_reg <= filt_valid_next;
            env_valid_reg  <= env_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign audio.ready = (state_reg == ST_IDLE);

    // ------------------------------------------------------------------
    // Memories: filter rows (carrier words above formant words) and envelopes
    // ------------------------------------------------------------------
    logic [255:0] filt_mem [MAX_BAND_COUNT];
    logic [23:0]  env_mem  [MAX_BAND_COUNT];
    logic [255:0] filt_q_reg;
    logic         filt_ok_reg;
    logic [23:0]  env_q_reg;
    logic         env_ok_reg;

    cvoc_row_t    c_row, f_row;
    logic [23:0]  env_reg, env_next;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_M5)
            filt_mem[band_reg] <= {c_row, f_row};
        if (state_reg == ST_E2)
            env_mem[band_reg] <= env_next;
        if (rd_en)
        begin
            filt_q_reg  <= filt_mem[rd_band];
            filt_ok_reg <= filt_valid_reg[rd_band];
            env_q_reg   <= env_mem[rd_band];
            env_ok_reg  <= env_valid_reg[rd_band];
        end
    end

    // ------------------------------------------------------------------
    // Coefficient and level fetch, alongside the row read
    // ------------------------------------------------------------------
    cvoc_coef_t   coef_reg;
    logic [7:0]   lvl_reg;
    logic [5:0]   lvl_idx;
    logic [127:0] lvl_all;
    logic [7:0]   lvl_byte;
    logic [7:0]   lvl_pick;

    assign lvl_idx  = 6'(rd_band);
    assign lvl_all  = {band_levels_high_reg, band_levels_low_reg};
    assign lvl_byte = lvl_all[{lvl_idx[3:0], 3'b000} +: 8];
    // Bands past sixteen run at unity; bytes above 1.0 clamp to it
    assign lvl_pick = (lvl_idx < 6'd16) ? lvl_byte : 8'd128;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            coef_reg <= coef_rom[active_m1][rd_band];
            lvl_reg  <= (lvl_pick > 8'd128) ? 8'd128 : lvl_pick;
        end
    end

    // ------------------------------------------------------------------
    // Filter lanes
    // ------------------------------------------------------------------
    logic signed [16:0] fx_reg, cx_reg;
    logic               eob_reg;
    cvoc_row_t          row_masked;
    cvoc_row_t          c_row_in, f_row_in;
    logic signed [31:0] cy, fy;

    assign row_masked = filt_ok_reg ? filt_q_reg[255:128] : '0;
    assign c_row_in   = row_masked;
    assign f_row_in   = filt_ok_reg ? filt_q_reg[127:0] : '0;

    cvoc_lane u_carrier (
        .clk     (clk),
        .state   (state_reg),
        .coef    (coef_reg),
        .x       (cx_reg),
        .row_in  (c_row_in),
        .row_out (c_row),
        .y       (cy)
    );

    cvoc_lane u_formant (
        .clk     (clk),
        .state   (state_reg),
        .coef    (coef_reg),
        .x       (fx_reg),
        .row_in  (f_row_in),
        .row_out (f_row),
        .y       (fy)
    );

    // ------------------------------------------------------------------
    // Envelope follower, band mix and output scaling
    // ------------------------------------------------------------------
    logic signed [37:0]      dmul_reg, dmul_next;
    logic signed [56:0]      cm_reg, cm_next;
    logic signed [49:0]      lm_reg, lm_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [42:0]      vm_reg, vm_next;
    logic signed [15:0]      out_sample_reg, out_sample_next;
    logic                    out_eob_reg, out_eob_next;

    logic signed [32:0] fy_neg;
    logic [32:0]        fy_mag;
    logic [23:0]        ya;
    logic signed [24:0] env_diff;
    logic signed [19:0] dmul_sh;
    logic signed [25:0] env_sum;
    logic signed [40:0] cm_sh;
    logic signed [42:0] lm_sh;
    logic signed [25:0] acc_clip;
    logic signed [33:0] r_sh;

    assign fy_neg   = -(33'(fy));
    assign fy_mag   = fy[31] ? fy_neg : 33'(fy);
    assign ya       = (fy_mag > 33'h0FFFFFF) ? 24'hFFFFFF : fy_mag[23:0];
    assign env_diff = $signed({1'b0, ya}) - $signed({1'b0, env_reg});
    assign dmul_sh  = dmul_reg[37:18];
    assign env_sum  = 26'($signed({1'b0, env_reg})) + 26'(dmul_sh);
    assign cm_sh    = cm_reg[56:16];
    assign lm_sh    = lm_reg[49:7];
    // Past 2^24 the scaled result saturates for any non-zero volume
    assign acc_clip = (acc_reg > ACC_HI) ? 26'(ACC_HI) :
                      (acc_reg < ACC_LO) ? 26'(ACC_LO) : 26'(acc_reg);
    assign r_sh     = vm_reg[42:9];

    always_comb
    begin
        env_next        = env_reg;
        dmul_next       = dmul_reg;
        cm_next         = cm_reg;
        lm_next         = lm_reg;
        acc_next        = acc_reg;
        vm_next         = vm_reg;
        out_sample_next = out_sample_reg;
        out_eob_next    = out_eob_reg;
        unique case (state_reg)
            ST_IDLE:
                acc_next = '0;
            ST_LD:
                env_next = env_ok_reg ? env_q_reg : 24'd0;
            ST_E1:
                dmul_next = env_diff * $signed({1'b0, coef_reg.decay});
            ST_E2:
            begin
                if (env_sum < 26'sd0)
                    env_next = 24'd0;
                else if (env_sum > 26'sh0FFFFFF)
                    env_next = 24'hFFFFFF;
                else
                    env_next = env_sum[23:0];
            end
            ST_C1:
                cm_next = cy * $signed({1'b0, env_reg});
            ST_C2:
                lm_next = cm_sh * $signed({1'b0, lvl_reg});
            ST_AC:
                acc_next = acc_reg + ACC_W'(lm_sh);
            ST_V1:
                vm_next = acc_clip * $signed({1'b0, main_volume_reg});
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_eob_next = eob_reg;
                    if (r_sh > 34'sd32767)
                        out_sample_next = 16'sh7FFF;
                    else if (r_sh < -34'sd32768)
                        out_sample_next = 16'sh8000;
                    else
                        out_sample_next = r_sh[15:0];
                end
            end
            default:
                acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            // Q1.15 samples enter the filters as Q16.16
            fx_reg  <= {audio.formant_sample, 1'b0};
            cx_reg  <= {audio.carrier_sample, 1'b0};
            eob_reg <= audio.end_of_block;
        end
        env_reg        <= env_next;
        dmul_reg       <= dmul_next;
        cm_reg         <= cm_next;
        lm_reg         <= lm_next;
        acc_reg        <= acc_next;
        vm_reg         <= vm_next;
        out_sample_reg <= out_sample_next;
        out_eob_reg    <= out_eob_next;
    end

    assign vocoded.valid            = out_valid_reg;
    assign vocoded.vocoded_sample   = out_sample_reg;
    assign vocoded.end_of_block_out = out_eob_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the final step");

    a_count_change_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (n_eff != active_reg)) |=> (filt_valid_reg == '0))
        else $error("filter rows not dropped on band count change");

    a_band_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (CW'(band_reg) < active_reg))
        else $error("band index past the active band count");

endmodule

`default_nettype wire
